@@ hdl/ppst_pkg.sv @@
// Package for the pulse programmed sleep timer: item types, register map and
// the power-of-ten table. No dependencies.
package ppst_pkg;

    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned SLEEP_W    = 32;
    localparam int unsigned COUNT_W    = 8;
    localparam int unsigned POW_MAX    = 9;

    // Register index is paddr divided by four.
    localparam logic REG_WAKE_DELAY = 1'b0;

    localparam logic [COUNT_W-1:0] WAKE_DELAY_RESET = 8'd1;

    typedef struct packed {
        logic select_level;
        logic pulse_level;
        logic second_tick;
    } t_in_item;

    typedef struct packed {
        logic                regulator_enable;
        logic [1:0]          phase;
        logic [SLEEP_W-1:0]  sleep_seconds;
    } t_out_item;

    // Powers of ten that fit in 32 bits.
    function automatic logic [SLEEP_W-1:0] pow10(input logic [3:0] n);
        logic [SLEEP_W-1:0] v;
        case (n)
            4'd0:    v = 32'd1;
            4'd1:    v = 32'd10;
            4'd2:    v = 32'd100;
            4'd3:    v = 32'd1000;
            4'd4:    v = 32'd10000;
            4'd5:    v = 32'd100000;
            4'd6:    v = 32'd1000000;
            4'd7:    v = 32'd10000000;
            4'd8:    v = 32'd100000000;
            4'd9:    v = 32'd1000000000;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

@@ hdl/ppst_cfg.sv @@
// APB-style register file for the sleep timer: holds the wake delay.
// Depends on ppst_pkg.
module ppst_cfg import ppst_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [COUNT_W-1:0]    o_wake_delay
);

    logic [COUNT_W-1:0] r_wake_delay;
    logic               w_sel_delay;

    assign w_sel_delay = (paddr[CFG_ADDR_W-1] == REG_WAKE_DELAY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wake_delay <= WAKE_DELAY_RESET;
        end else if (psel && penable && pwrite && w_sel_delay) begin
            r_wake_delay <= pwdata[COUNT_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (w_sel_delay) begin
            prdata = {{(CFG_DATA_W-COUNT_W){1'b0}}, r_wake_delay};
        end
    end

    assign pready       = 1'b1;
    assign o_wake_delay = r_wake_delay;

endmodule

@@ hdl/ppst_sleep_calc.sv @@
// Sleep time factor * 10^(exponent-1), exponent 0 taken as 1, saturated to 32 bits.
// Depends on ppst_pkg.
module ppst_sleep_calc import ppst_pkg::*; (
    input  logic [COUNT_W-1:0] i_exponent,
    input  logic [COUNT_W-1:0] i_factor,
    output logic [SLEEP_W-1:0] o_sleep
);

    logic [COUNT_W-1:0]         w_pow;
    logic [SLEEP_W+COUNT_W-1:0] w_prod;

    always_comb begin
        w_pow  = (i_exponent == '0) ? '0 : i_exponent - 8'd1;
        w_prod = {{COUNT_W{1'b0}}, pow10(w_pow[3:0])} *
                 {{SLEEP_W{1'b0}}, i_factor};
        if (i_factor == '0) begin
            o_sleep = '0;
        end else if (w_pow > COUNT_W'(POW_MAX) || w_prod[SLEEP_W+COUNT_W-1:SLEEP_W] != '0) begin
            o_sleep = '1;
        end else begin
            o_sleep = w_prod[SLEEP_W-1:0];
        end
    end

endmodule

@@ hdl/ppst_core.sv @@
// Sequencer of the sleep timer: waking wait, exponent and factor burst
// counting, sleep countdown. Depends on ppst_pkg and ppst_sleep_calc.
module ppst_core import ppst_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  t_in_item           i_item,
    input  logic [COUNT_W-1:0] i_wake_delay,
    output t_out_item          o_result
);

    typedef enum logic [1:0] {
        PH_WAKING   = 2'd0,
        PH_EXPONENT = 2'd1,
        PH_FACTOR   = 2'd2,
        PH_SLEEPING = 2'd3
    } t_phase;

    t_phase             r_phase,  n_phase;
    logic [COUNT_W-1:0] r_burst,  n_burst;
    logic               r_pip,    n_pip;
    logic [COUNT_W-1:0] r_expo,   n_expo;
    logic [SLEEP_W-1:0] r_remain, n_remain;
    logic [COUNT_W-1:0] r_wait,   n_wait;
    logic               r_enable, n_enable;
    logic [SLEEP_W-1:0] r_held,   n_held;
    logic [SLEEP_W-1:0] w_calc;
    logic [SLEEP_W-1:0] w_remain_dec;
    logic [COUNT_W-1:0] w_factor;
    logic               w_wake;

    // Burst count including a pulse that ends on this item.
    assign w_factor = (r_pip && !i_item.pulse_level) ? r_burst + 8'd1 : r_burst;

    ppst_sleep_calc u_calc (
        .i_exponent (r_expo),
        .i_factor   (w_factor),
        .o_sleep    (w_calc)
    );

    assign w_remain_dec = r_remain - 32'd1;

    always_comb begin
        n_phase  = r_phase;
        n_burst  = r_burst;
        n_pip    = r_pip;
        n_expo   = r_expo;
        n_remain = r_remain;
        n_wait   = r_wait;
        n_enable = r_enable;
        n_held   = r_held;
        w_wake   = 1'b0;
        case (r_phase)
            PH_WAKING: begin
                if (i_item.second_tick && r_wait != '1) begin
                    n_wait = r_wait + 8'd1;
                end
                if (n_wait >= i_wake_delay) begin
                    n_enable = 1'b1;
                    n_phase  = PH_EXPONENT;
                    n_burst  = '0;
                    n_pip    = 1'b0;
                end
            end
            PH_EXPONENT, PH_FACTOR: begin
                if (r_pip) begin
                    if (!i_item.pulse_level) begin
                        n_burst = r_burst + 8'd1;
                        n_pip   = 1'b0;
                    end
                end else if (i_item.select_level && i_item.pulse_level) begin
                    n_pip = 1'b1;
                end
                // The burst closes once select is low and no pulse is pending.
                if (!n_pip && !i_item.select_level) begin
                    if (n_burst != '0) begin
                        if (r_phase == PH_EXPONENT) begin
                            n_expo  = n_burst;
                            n_phase = PH_FACTOR;
                        end else begin
                            n_held   = w_calc;
                            n_remain = w_calc;
                            n_enable = 1'b0;
                            n_phase  = PH_SLEEPING;
                        end
                    end
                    n_burst = '0;
                end
            end
            default: begin
                if (r_remain == '0) begin
                    w_wake = 1'b1;
                end else if (i_item.second_tick) begin
                    n_remain = w_remain_dec;
                    if (w_remain_dec == '0) begin
                        w_wake = 1'b1;
                    end
                end
            end
        endcase
        if (w_wake) begin
            n_phase  = PH_WAKING;
            n_wait   = '0;
            n_expo   = 8'd1;
            n_burst  = '0;
            n_pip    = 1'b0;
            n_enable = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_WAKING;
            r_burst  <= '0;
            r_pip    <= 1'b0;
            r_expo   <= 8'd1;
            r_remain <= '0;
            r_wait   <= '0;
            r_enable <= 1'b0;
            r_held   <= '0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_burst  <= n_burst;
            r_pip    <= n_pip;
            r_expo   <= n_expo;
            r_remain <= n_remain;
            r_wait   <= n_wait;
            r_enable <= n_enable;
            r_held   <= n_held;
        end
    end

    assign o_result.regulator_enable = n_enable;
    assign o_result.phase            = 2'(n_phase);
    assign o_result.sleep_seconds    = n_held;

endmodule

@@ hdl/pulse_programmed_sleep_timer.sv @@
// Pulse programmed sleep timer, top level. Depends on ppst_pkg, ppst_cfg, ppst_core.
// An accepted item is loaded into the input register, and its result into the result
// register when the sequencer steps on it; a full result register stalls that step.
// Throughput: one item per cycle while the output is not stalled.
// Reset (i_rst_n low, synchronous): pipeline empty, waking phase, wake delay 1.
module pulse_programmed_sleep_timer import ppst_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic               r_in_valid;
    t_in_item           r_in;
    logic               r_out_valid;
    t_out_item          r_out;
    logic               w_step;
    t_out_item          w_result;
    logic [COUNT_W-1:0] w_wake_delay;

    ppst_cfg u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_wake_delay (w_wake_delay)
    );

    ppst_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_step),
        .i_item       (r_in),
        .i_wake_delay (w_wake_delay),
        .o_result     (w_result)
    );

    // The held item is processed when the result register is free or drains now.
    assign w_step     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_step) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in;
        end
        if (w_step) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

@@ verif/tb_pulse_programmed_sleep_timer.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the pulse programmed sleep timer: a queue-fed driver,
// a result monitor and a per-item timer predictor. Depends on ppst_pkg and the RTL.
module tb_pulse_programmed_sleep_timer;
    import ppst_pkg::*;

    typedef enum logic [1:0] {
        PH_WAKING   = 2'd0,
        PH_EXPONENT = 2'd1,
        PH_FACTOR   = 2'd2,
        PH_SLEEPING = 2'd3
    } t_phase;

    localparam logic [CFG_ADDR_W-1:0] ADDR_WAKE_DELAY = {REG_WAKE_DELAY, 2'b00};
    localparam logic [CFG_ADDR_W-1:0] ADDR_NO_REG     = {~REG_WAKE_DELAY, 2'b00};
    localparam int                    IDLE_PCT        = 20;
    localparam int                    RANDOM_SAMPLES  = 350;
    localparam longint unsigned       SAT_LIMIT       = 64'hFFFF_FFFF;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    t_in_item              i_in        = '0;
    logic                  i_out_ready = 1'b0;
    logic                  psel        = 1'b0;
    logic                  penable     = 1'b0;
    logic                  pwrite      = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr       = '0;
    logic [CFG_DATA_W-1:0] pwdata      = '0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    t_out_item             o_out;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    pulse_programmed_sleep_timer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // Predicted timer state.
    logic [7:0]  wake_delay;
    t_phase      ph;
    logic [7:0]  burst_cnt;
    logic        pulse_busy;
    logic [7:0]  expo;
    logic [31:0] sleep_left;
    logic [7:0]  wake_ticks;
    logic        en;
    logic [31:0] held_sleep;

    t_in_item  sample_q[$];
    t_out_item status_due_q[$];

    int   err_count  = 0;
    int   n_accepted = 0;
    int   n_checked  = 0;
    int   n_sleeps   = 0;
    int   n_writes   = 0;
    int   planned    = 0;
    bit   steady     = 1'b0;
    logic in_taken   = 1'b0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("%0t: timeout, stimulus or results stalled", $time);
        $display("FAILED: results differ");
        $finish;
    end

    function automatic logic [31:0] sleep_product(input logic [7:0] e, input logic [7:0] f);
        logic [63:0] v;
        int          n;
        v = 64'(f);
        n = (e > 0) ? int'(e) - 1 : 0;
        for (int k = 0; k < n; k++) begin
            if (v > SAT_LIMIT / 10)
                return 32'hFFFF_FFFF;
            v = v * 10;
        end
        return v[31:0];
    endfunction

    task automatic restart_waking();
        ph         = PH_WAKING;
        wake_ticks = '0;
        expo       = 8'd1;
        burst_cnt  = '0;
        pulse_busy = 1'b0;
        en         = 1'b0;
    endtask

    task automatic timer_reset();
        wake_delay = WAKE_DELAY_RESET;
        restart_waking();
        sleep_left = '0;
        held_sleep = '0;
    endtask

    task automatic timer_step(input t_in_item s, output t_out_item res);
        case (ph)
            PH_WAKING: begin
                if (s.second_tick && wake_ticks != 8'hFF)
                    wake_ticks = wake_ticks + 8'd1;
                if (wake_ticks >= wake_delay) begin
                    en         = 1'b1;
                    ph         = PH_EXPONENT;
                    burst_cnt  = '0;
                    pulse_busy = 1'b0;
                end
            end
            PH_EXPONENT, PH_FACTOR: begin
                // A pulse is counted on its falling level, whatever select does then.
                if (pulse_busy) begin
                    if (!s.pulse_level) begin
                        burst_cnt  = burst_cnt + 8'd1;
                        pulse_busy = 1'b0;
                    end
                end else if (s.select_level && s.pulse_level) begin
                    pulse_busy = 1'b1;
                end
                if (!pulse_busy && !s.select_level) begin
                    if (burst_cnt != 0) begin
                        if (ph == PH_EXPONENT) begin
                            expo = burst_cnt;
                            ph   = PH_FACTOR;
                        end else begin
                            held_sleep = sleep_product(expo, burst_cnt);
                            sleep_left = held_sleep;
                            en         = 1'b0;
                            ph         = PH_SLEEPING;
                            n_sleeps++;
                        end
                    end
                    burst_cnt = '0;
                end
            end
            default: begin
                if (sleep_left == 0) begin
                    restart_waking();
                end else if (s.second_tick) begin
                    sleep_left = sleep_left - 1;
                    if (sleep_left == 0)
                        restart_waking();
                end
            end
        endcase
        res.regulator_enable = en;
        res.phase            = ph;
        res.sleep_seconds    = held_sleep;
    endtask

    task automatic field_check(input string what, input logic [31:0] want,
                               input logic [31:0] got_v);
        if (got_v !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got_v);
            err_count++;
        end
    endtask

    // Input side: predict each item as it is accepted.
    always @(posedge i_clk) begin : accept_side
        t_out_item predicted;
        in_taken <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            timer_step(i_in, predicted);
            status_due_q.push_back(predicted);
            n_accepted++;
        end
    end

    always @(negedge i_clk) begin
        if (!i_in_valid || in_taken) begin
            if (sample_q.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
                i_in_valid <= 1'b1;
                i_in       <= sample_q.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        i_out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin : result_side
        t_out_item due;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (status_due_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, o_out);
                err_count++;
            end else begin
                due = status_due_q.pop_front();
                field_check("regulator_enable", 32'(due.regulator_enable),
                            32'(o_out.regulator_enable));
                field_check("phase", 32'(due.phase), 32'(o_out.phase));
                field_check("sleep_seconds", due.sleep_seconds, o_out.sleep_seconds);
                n_checked++;
            end
        end
    end

    // Writes one register, then reads the wake delay back.
    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [7:0] val);
        logic [CFG_DATA_W-1:0] data;
        data      = $urandom();
        data[7:0] = val;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (addr == ADDR_WAKE_DELAY)
            wake_delay = val;
        n_writes++;
        @(negedge i_clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        paddr   <= ADDR_WAKE_DELAY;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== {{(CFG_DATA_W-8){1'b0}}, wake_delay}) begin
            $display("%0t: wake delay readback mismatch, expected %0d, actual %0d",
                     $time, wake_delay, prdata);
            err_count++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (sample_q.size() != 0 || i_in_valid || status_due_q.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic bit rand_pct(input int pct);
        return $urandom_range(99) < pct;
    endfunction

    task automatic push_item(input bit sel, input bit pls, input bit tck);
        t_in_item s;
        s.select_level = sel;
        s.pulse_level  = pls;
        s.second_tick  = tck;
        sample_q.push_back(s);
        planned++;
    endtask

    // Ticks until the enable comes on, or only half of them when partial is set.
    task automatic gen_wake(input bit partial);
        int need;
        int got;
        bit t;
        need = (wake_delay > wake_ticks) ? int'(wake_delay) - int'(wake_ticks) : 0;
        got  = 0;
        if (partial && need >= 2)
            need = need / 2;
        if (need == 0)
            push_item(rand_pct(50), rand_pct(50), rand_pct(50));
        while (got < need) begin
            t = rand_pct(60);
            push_item(rand_pct(50), rand_pct(50), t);
            if (t)
                got++;
        end
    endtask

    task automatic gen_sleep();
        int got;
        bit t;
        got = 0;
        if (sleep_left == 0)
            push_item(rand_pct(50), rand_pct(50), rand_pct(50));
        while (got < int'(sleep_left)) begin
            t = rand_pct(70);
            push_item(rand_pct(50), rand_pct(50), t);
            if (t)
                got++;
        end
    endtask

    // One framed burst of n pulses; n of zero gives an empty frame.
    task automatic gen_burst(input int n);
        int k;
        int hold;
        if (rand_pct(20)) begin
            // A stray pulse outside the frame must not start a count.
            push_item(1'b0, 1'b1, rand_pct(25));
            push_item(1'b0, 1'b0, rand_pct(25));
        end
        repeat ($urandom_range(1, 2)) push_item(1'b1, 1'b0, rand_pct(25));
        for (k = 0; k < n; k++) begin
            hold = $urandom_range(1, 3);
            repeat (hold) push_item(1'b1, 1'b1, rand_pct(25));
            if (k == n - 1) begin
                case ($urandom_range(2))
                    0: push_item(1'b1, 1'b0, rand_pct(25));
                    1: ;
                    default: push_item(1'b0, 1'b1, rand_pct(25));
                endcase
            end else begin
                repeat ($urandom_range(1, 2)) push_item(1'b1, 1'b0, rand_pct(25));
            end
        end
        push_item(1'b0, 1'b0, rand_pct(25));
    endtask

    function automatic logic [7:0] pick_delay();
        int p;
        p = $urandom_range(99);
        if (p < 25)
            return 8'd0;
        else if (p < 85)
            return 8'($urandom_range(1, 6));
        else if (p < 95)
            return 8'($urandom_range(7, 15));
        return 8'($urandom_range(20, 40));
    endfunction

    // Feeds items for the current phase, which may or may not end it; called only with nothing in flight.
    task automatic advance_step();
        int pick;
        pick = $urandom_range(99);
        case (ph)
            PH_WAKING: begin
                if (rand_pct(30))
                    cfg_write(ADDR_WAKE_DELAY, pick_delay());
                if (rand_pct(10))
                    cfg_write(ADDR_NO_REG, 8'($urandom()));
                gen_wake(rand_pct(20));
            end
            PH_EXPONENT: gen_burst(pick < 5 ? 0 : pick < 55 ? 1 : pick < 90 ? 2 : 3);
            PH_FACTOR: begin
                if (pick < 5)
                    gen_burst(0);
                else if (expo <= 2)
                    gen_burst($urandom_range(1, 9));
                else
                    gen_burst($urandom_range(1, 3));
            end
            default: gen_sleep();
        endcase
    endtask

    initial begin : stimulus
        int iter;
        int guard;
        timer_reset();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // A write with no register behind it must leave the reset delay in place.
        cfg_write(ADDR_NO_REG, 8'hFF);

        push_item(1'b0, 1'b0, 1'b0);
        push_item(1'b1, 1'b1, 1'b1);
        push_item(1'b1, 1'b0, 1'b0);
        push_item(1'b1, 1'b1, 1'b0);
        push_item(1'b0, 1'b0, 1'b0);
        push_item(1'b1, 1'b0, 1'b0);
        push_item(1'b0, 1'b0, 1'b0);
        push_item(1'b1, 1'b1, 1'b0);
        push_item(1'b1, 1'b0, 1'b0);
        push_item(1'b1, 1'b1, 1'b0);
        push_item(1'b0, 1'b1, 1'b0);
        push_item(1'b0, 1'b0, 1'b0);
        push_item(1'b1, 1'b1, 1'b0);
        push_item(1'b0, 1'b0, 1'b1);
        push_item(1'b1, 1'b1, 1'b1);

        // Zero delay: the enable comes on at the first waking item.
        wait_drained();
        cfg_write(ADDR_WAKE_DELAY, 8'd0);
        push_item(1'b0, 1'b0, 1'b0);
        gen_burst(2);
        gen_burst(1);
        wait_drained();
        gen_sleep();

        // Longest delay, then a 256-pulse burst that wraps to zero and is dropped.
        wait_drained();
        cfg_write(ADDR_WAKE_DELAY, 8'd255);
        repeat (255) push_item(rand_pct(50), rand_pct(50), 1'b1);
        wait_drained();
        push_item(1'b1, 1'b0, rand_pct(25));
        repeat (256) begin
            push_item(1'b1, 1'b1, rand_pct(25));
            push_item(1'b1, 1'b0, rand_pct(25));
        end
        push_item(1'b0, 1'b0, rand_pct(25));
        gen_burst(1);
        gen_burst(3);
        wait_drained();
        gen_sleep();

        // Lowering the delay below the ticks already seen ends the wait at once.
        wait_drained();
        cfg_write(ADDR_WAKE_DELAY, 8'd200);
        repeat (50) push_item(1'b0, 1'b0, 1'b1);
        wait_drained();
        cfg_write(ADDR_WAKE_DELAY, 8'd20);
        push_item(1'b0, 1'b0, 1'b0);

        iter    = 0;
        planned = 0;
        while (planned < RANDOM_SAMPLES) begin
            steady = (iter >= 4 && iter < 10);
            wait_drained();
            advance_step();
            iter++;
        end
        steady = 1'b0;

        // A huge exponent saturates the product; the timer then sleeps for good.
        wait_drained();
        while (ph != PH_EXPONENT) begin
            advance_step();
            wait_drained();
        end
        gen_burst(10);
        gen_burst(7);
        repeat (10) push_item(rand_pct(50), rand_pct(50), rand_pct(50));

        guard = 0;
        while ((sample_q.size() != 0 || i_in_valid || status_due_q.size() != 0)
               && guard < 5000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (10) @(posedge i_clk);
        if (status_due_q.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, status_due_q.size());
            err_count += status_due_q.size();
        end

        $display("Run: %0d sample items accepted, %0d status results checked,", n_accepted,
                 n_checked);
        $display("     %0d sleep periods entered, %0d register writes.", n_sleeps, n_writes);
        if (err_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

@@ files.f @@
hdl/ppst_pkg.sv
hdl/ppst_cfg.sv
hdl/ppst_sleep_calc.sv
hdl/ppst_core.sv
hdl/pulse_programmed_sleep_timer.sv
verif/tb_pulse_programmed_sleep_timer.sv
